// ----- hw/rtl/bdp_pkg.sv -----
// Shared types and constants for the branch direction predictor.
// Depends on nothing; every other file of the block takes names from here.
package bdp_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned TABLE_ENTRIES_DEF = 256;
    localparam int unsigned COUNT_WIDTH_DEF   = 32;

    // Fixed field widths.
    localparam int unsigned PC_W        = 32;
    localparam int unsigned OUT_COUNT_W = 32;
    localparam int unsigned CTR_W       = 2;

    // Depth of the queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // A classified branch as it travels from the front to the back part.
    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic            taken;
    } item_t;

    // Status from the back part to the front part.
    typedef struct packed {
        logic clear_done;
    } back_status_t;

    // One predictor table entry. The full address is kept, which makes the
    // hit test equal to an index match plus a tag match.
    typedef struct packed {
        logic             valid;
        logic [PC_W-1:0]  pc;
        logic             last;
        logic [CTR_W-1:0] ctr;
    } entry_t;

endpackage

// ----- hw/rtl/bdp_if.sv -----
// Valid/ready channel interfaces for resolved branches and predictor results.
// Depends on bdp_pkg for the field widths.
interface bdp_in_if;
    logic                    valid;
    logic                    ready;
    logic [bdp_pkg::PC_W-1:0] branch_pc;
    logic [bdp_pkg::PC_W-1:0] offset_magnitude;
    logic                    offset_positive;
    logic [bdp_pkg::PC_W-1:0] next_pc;

    modport source (
        output valid, branch_pc, offset_magnitude, offset_positive, next_pc,
        input  ready
    );
    modport sink (
        input  valid, branch_pc, offset_magnitude, offset_positive, next_pc,
        output ready
    );
endinterface

interface bdp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           was_taken;
    logic                           first_sighting;
    logic                           one_bit_guess;
    logic                           two_bit_guess;
    logic [bdp_pkg::OUT_COUNT_W-1:0] branch_count;
    logic [bdp_pkg::OUT_COUNT_W-1:0] taken_count;
    logic [bdp_pkg::OUT_COUNT_W-1:0] scored_count;
    logic [bdp_pkg::OUT_COUNT_W-1:0] one_bit_hits;
    logic [bdp_pkg::OUT_COUNT_W-1:0] two_bit_hits;

    modport source (
        output valid, was_taken, first_sighting, one_bit_guess, two_bit_guess,
               branch_count, taken_count, scored_count, one_bit_hits, two_bit_hits,
        input  ready
    );
    modport sink (
        input  valid, was_taken, first_sighting, one_bit_guess, two_bit_guess,
               branch_count, taken_count, scored_count, one_bit_hits, two_bit_hits,
        output ready
    );
endinterface

// ----- hw/rtl/bdp_front.sv -----
// Front part: accepts a resolved branch, decides taken or not taken and
// works out the table index. Depends on bdp_pkg and bdp_in_if.
module bdp_front #(
    parameter  int unsigned TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEF,
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bdp_in_if.sink                branch,
    input  bdp_pkg::back_status_t status,
    output logic                  push_valid,
    input  logic                  push_ready,
    output bdp_pkg::item_t        push_item,
    output logic [IDX_W-1:0]      push_idx
);

    localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));

    // The folded address is a sum of four bytes times weights below 2^16,
    // so it always fits in 26 bits.
    localparam int unsigned FOLD_W  = 26;
    localparam int unsigned RECIP_W = FOLD_W + 2;
    localparam int unsigned PROD_W  = FOLD_W + RECIP_W;
    localparam int unsigned SHIFT   = FOLD_W + IDX_W;

    // Weight of each address byte modulo the table size.
    localparam logic [FOLD_W-1:0] BYTE_WT0 = FOLD_W'(64'd1 % 64'(TABLE_ENTRIES));
    localparam logic [FOLD_W-1:0] BYTE_WT1 = FOLD_W'(64'd256 % 64'(TABLE_ENTRIES));
    localparam logic [FOLD_W-1:0] BYTE_WT2 = FOLD_W'(64'd65536 % 64'(TABLE_ENTRIES));
    localparam logic [FOLD_W-1:0] BYTE_WT3 = FOLD_W'(64'd16777216 % 64'(TABLE_ENTRIES));

    // Rounded-up reciprocal; exact for every folded value below 2^FOLD_W.
    localparam logic [FOLD_W-1:0]  ENTRIES_F = FOLD_W'(TABLE_ENTRIES);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_QUOT,
        FR_REM,
        FR_PUSH
    } fr_state_t;

    fr_state_t                      state_reg;
    bdp_pkg::item_t                 item_reg;
    logic [FOLD_W-1:0]              fold_reg;
    logic [FOLD_W-1:0]              quot_reg;
    logic [IDX_W-1:0]               rem_reg;

    logic [bdp_pkg::PC_W-1:0]       target;
    logic                           taken_in;
    logic                           accept;
    logic [FOLD_W-1:0]              fold_in;
    logic [PROD_W-1:0]              prod;
    logic [FOLD_W-1:0]              quot_next;
    logic [FOLD_W-1:0]              rem_full;

    // Branch target and the taken decision, both modulo 2^32.
    assign target   = branch.offset_positive ? branch.branch_pc + branch.offset_magnitude
                                             : branch.branch_pc - branch.offset_magnitude;
    assign taken_in = (branch.next_pc == target);

    assign branch.ready = (state_reg == FR_IDLE) && status.clear_done;
    assign accept       = branch.valid && branch.ready;

    // Fold the address bytes into a small value with the same remainder.
    assign fold_in = FOLD_W'(branch.branch_pc[7:0])   * BYTE_WT0
                   + FOLD_W'(branch.branch_pc[15:8])  * BYTE_WT1
                   + FOLD_W'(branch.branch_pc[23:16]) * BYTE_WT2
                   + FOLD_W'(branch.branch_pc[31:24]) * BYTE_WT3;

    // Quotient by reciprocal multiplication, then the remainder.
    assign prod      = PROD_W'(fold_reg) * PROD_W'(RECIP);
    assign quot_next = FOLD_W'(prod >> SHIFT);
    assign rem_full  = fold_reg - quot_reg * ENTRIES_F;

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            case (state_reg)
                FR_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= IS_POW2 ? FR_PUSH : FR_QUOT;
                    end
                end
                FR_QUOT:
                begin
                    state_reg <= FR_REM;
                end
                FR_REM:
                begin
                    state_reg <= FR_PUSH;
                end
                FR_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= FR_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= FR_IDLE;
                end
            endcase
        end
    end

    // Captured request and the index being worked out.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pc    <= branch.branch_pc;
            item_reg.taken <= taken_in;
            fold_reg       <= fold_in;
            rem_reg        <= IS_POW2 ? branch.branch_pc[IDX_W-1:0] : '0;
        end
        else if (state_reg == FR_QUOT)
        begin
            quot_reg <= quot_next;
        end
        else if (state_reg == FR_REM)
        begin
            rem_reg <= rem_full[IDX_W-1:0];
        end
    end

    assign push_valid = (state_reg == FR_PUSH);
    assign push_item  = item_reg;
    assign push_idx   = rem_reg;

endmodule

// ----- hw/rtl/bdp_queue.sv -----
// Short first-in first-out queue that decouples the front and back parts.
// Depends on bdp_pkg for its depth.
module bdp_queue #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int unsigned PTR_W = $clog2(bdp_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] slot_reg [bdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != CNT_W'(bdp_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(bdp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(bdp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/bdp_back.sv -----
// Back part: predictor table read-modify-write, scoring, running counts and
// the result register. Depends on bdp_pkg and bdp_out_if.
module bdp_back #(
    parameter  int unsigned TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEF,
    parameter  int unsigned COUNT_WIDTH   = bdp_pkg::COUNT_WIDTH_DEF,
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  bdp_pkg::item_t        q_item,
    input  logic [IDX_W-1:0]      q_idx,
    output bdp_pkg::back_status_t status,
    bdp_out_if.source             result
);

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } bk_state_t;

    bdp_pkg::entry_t    mem [TABLE_ENTRIES];
    bdp_pkg::entry_t    rd_data_reg;

    bk_state_t          state_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    bdp_pkg::item_t     cur_item_reg;
    logic [IDX_W-1:0]   cur_idx_reg;

    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] taken_cnt_reg;
    logic [COUNT_WIDTH-1:0] scored_reg;
    logic [COUNT_WIDTH-1:0] one_hits_reg;
    logic [COUNT_WIDTH-1:0] two_hits_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic [COUNT_WIDTH-1:0] taken_cnt_next;
    logic [COUNT_WIDTH-1:0] scored_next;
    logic [COUNT_WIDTH-1:0] one_hits_next;
    logic [COUNT_WIDTH-1:0] two_hits_next;

    logic               out_valid_reg;
    logic               was_taken_reg;
    logic               first_reg;
    logic               g1_reg;
    logic               g2_reg;

    logic               slot_free;
    logic               do_update;
    logic               rd_en;
    logic               hit;
    logic               g1;
    logic               g2;
    logic               taken;
    logic [bdp_pkg::CTR_W-1:0] ctr_next;
    bdp_pkg::entry_t    new_entry;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    bdp_pkg::entry_t    mem_wdata;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Handshake towards the queue and the result channel.
    assign q_ready           = (state_reg == BK_IDLE);
    assign rd_en             = q_valid && q_ready;
    assign slot_free         = !out_valid_reg || result.ready;
    assign do_update         = (state_reg == BK_UPDATE) && slot_free;
    assign status.clear_done = (state_reg != BK_CLEAR);

    // Lookup, scoring and the updated entry.
    always_comb
    begin
        taken = cur_item_reg.taken;
        hit   = rd_data_reg.valid && (rd_data_reg.pc == cur_item_reg.pc);
        g1    = hit && rd_data_reg.last;
        g2    = hit && rd_data_reg.ctr[1];

        ctr_next = rd_data_reg.ctr;
        if (taken && (rd_data_reg.ctr != '1))
        begin
            ctr_next = rd_data_reg.ctr + 1'b1;
        end
        else if (!taken && (rd_data_reg.ctr != '0))
        begin
            ctr_next = rd_data_reg.ctr - 1'b1;
        end

        new_entry.valid = 1'b1;
        new_entry.pc    = cur_item_reg.pc;
        new_entry.last  = hit ? taken : 1'b1;
        new_entry.ctr   = hit ? ctr_next : '0;
    end

    // Running counts after this request.
    always_comb
    begin
        total_next     = sat_inc(total_reg);
        taken_cnt_next = taken ? sat_inc(taken_cnt_reg) : taken_cnt_reg;
        scored_next    = hit ? sat_inc(scored_reg) : scored_reg;
        one_hits_next  = (hit && (g1 == taken)) ? sat_inc(one_hits_reg) : one_hits_reg;
        two_hits_next  = (hit && (g2 == taken)) ? sat_inc(two_hits_reg) : two_hits_reg;
    end

    // Table write port: clearing pass after reset, then updates.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx_reg;
        mem_wdata = new_entry;
        if (state_reg == BK_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (do_update)
        begin
            mem_we = 1'b1;
        end
    end

    // Predictor table with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[q_idx];
        end
    end

    // Request being worked on.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_item_reg <= q_item;
            cur_idx_reg  <= q_idx;
        end
    end

    // Sequencer, running counts and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            total_reg     <= '0;
            taken_cnt_reg <= '0;
            scored_reg    <= '0;
            one_hits_reg  <= '0;
            two_hits_reg  <= '0;
            out_valid_reg <= 1'b0;
            was_taken_reg <= 1'b0;
            first_reg     <= 1'b0;
            g1_reg        <= 1'b0;
            g2_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && !do_update)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                BK_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= BK_IDLE;
                    end
                end
                BK_IDLE:
                begin
                    if (rd_en)
                    begin
                        state_reg <= BK_UPDATE;
                    end
                end
                BK_UPDATE:
                begin
                    if (slot_free)
                    begin
                        total_reg     <= total_next;
                        taken_cnt_reg <= taken_cnt_next;
                        scored_reg    <= scored_next;
                        one_hits_reg  <= one_hits_next;
                        two_hits_reg  <= two_hits_next;
                        out_valid_reg <= 1'b1;
                        was_taken_reg <= taken;
                        first_reg     <= !hit;
                        g1_reg        <= g1;
                        g2_reg        <= g2;
                        state_reg     <= BK_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    // The counts only move when a new result is loaded, so they are shown directly.
    assign result.valid          = out_valid_reg;
    assign result.was_taken      = was_taken_reg;
    assign result.first_sighting = first_reg;
    assign result.one_bit_guess  = g1_reg;
    assign result.two_bit_guess  = g2_reg;
    assign result.branch_count   = bdp_pkg::OUT_COUNT_W'(total_reg);
    assign result.taken_count    = bdp_pkg::OUT_COUNT_W'(taken_cnt_reg);
    assign result.scored_count   = bdp_pkg::OUT_COUNT_W'(scored_reg);
    assign result.one_bit_hits   = bdp_pkg::OUT_COUNT_W'(one_hits_reg);
    assign result.two_bit_hits   = bdp_pkg::OUT_COUNT_W'(two_hits_reg);

endmodule

// ----- hw/rtl/branch_direction_predictor.sv -----
// Top level of the branch direction predictor: front part, queue and back part.
// Depends on bdp_pkg, bdp_if, bdp_front, bdp_queue and bdp_back.

// Each request is one resolved branch; the block answers with one result that
// says whether the branch was taken, whether its table entry was newly
// allocated, what the one-bit and two-bit predictors guessed before the update,
// and the saturating running counts after it. After reset the predictor table
// is cleared by a pass over all TABLE_ENTRIES entries, during which no request
// is taken. The front part takes a new request only after pushing the last
// one into the queue. With a power-of-two TABLE_ENTRIES the table index is the
// low address bits; otherwise the address bytes are folded modulo TABLE_ENTRIES
// as the request is taken, and a reciprocal multiplication in FR_QUOT and a
// subtraction in FR_REM give the index. The back part handles each request as
// a registered table read, then the table write and result load, and takes no
// new request until that load is done. A result waiting in the output register
// does not stop the front part, which keeps filling the two-entry queue.
module branch_direction_predictor #(
    parameter int unsigned TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned COUNT_WIDTH   = bdp_pkg::COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bdp_in_if.sink    branch,
    bdp_out_if.source result
);

    localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int unsigned ITEM_W = $bits(bdp_pkg::item_t);
    localparam int unsigned Q_W    = ITEM_W + IDX_W;

    bdp_pkg::back_status_t status;
    logic                  push_valid;
    logic                  push_ready;
    bdp_pkg::item_t        push_item;
    logic [IDX_W-1:0]      push_idx;
    logic                  q_valid;
    logic                  q_ready;
    logic [Q_W-1:0]        q_data;
    bdp_pkg::item_t        q_item;
    logic [IDX_W-1:0]      q_idx;

    // Classify incoming branches.
    bdp_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .branch     (branch),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_idx   (push_idx)
    );

    // Decoupling queue.
    bdp_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_idx, push_item}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign q_item = q_data[ITEM_W-1:0];
    assign q_idx  = q_data[Q_W-1:ITEM_W];

    // Table update, scoring and results.
    bdp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .q_idx   (q_idx),
        .status  (status),
        .result  (result)
    );

endmodule

// ----- hw/rtl/bdp_checker.sv -----
// Port-level assertions for the branch direction predictor, and the bind
// that attaches them to the top level. Depends on bdp_pkg.
module bdp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           first_sighting,
    input logic                           one_bit_guess,
    input logic                           two_bit_guess,
    input logic [bdp_pkg::OUT_COUNT_W-1:0] branch_count,
    input logic [bdp_pkg::OUT_COUNT_W-1:0] scored_count
);

    logic [bdp_pkg::OUT_COUNT_W-1:0] last_branch_reg;
    logic [bdp_pkg::OUT_COUNT_W-1:0] last_scored_reg;
    logic                            out_fire;

    assign out_fire = out_valid && out_ready;

    // Counts shown by the previous delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_branch_reg <= '0;
            last_scored_reg <= '0;
        end
        else if (out_fire)
        begin
            last_branch_reg <= branch_count;
            last_scored_reg <= scored_count;
        end
    end

    // A stalled result keeps its branch and scored counts and its first-sighting flag.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(branch_count)
            && $stable(scored_count) && $stable(first_sighting))
        else $error("stalled result changed");

    // A newly allocated entry gives no prediction.
    a_first_no_guess: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_sighting |-> !one_bit_guess && !two_bit_guess)
        else $error("guess shown on a first sighting");

    // Every delivered result counts exactly one more branch, unless saturated.
    a_branch_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (branch_count == last_branch_reg + 1'b1)
            || (branch_count == last_branch_reg))
        else $error("branch count did not step by one");

    // Only a scored branch moves the scored count.
    a_scored_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (first_sighting && (scored_count == last_scored_reg))
            || (!first_sighting && ((scored_count == last_scored_reg + 1'b1)
                || (scored_count == last_scored_reg))))
        else $error("scored count does not match first sighting");

endmodule

bind branch_direction_predictor bdp_checker u_bdp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .first_sighting (result.first_sighting),
    .one_bit_guess  (result.one_bit_guess),
    .two_bit_guess  (result.two_bit_guess),
    .branch_count   (result.branch_count),
    .scored_count   (result.scored_count)
);

// ----- verif/branch_direction_predictor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for branch_direction_predictor: directed table then random branches.
// Depends on bdp_pkg, bdp_if and the RTL of the block; results are checked against a local model or a typed row.
module branch_direction_predictor_tb;

    localparam int PC_W         = bdp_pkg::PC_W;
    localparam int CTR_W        = bdp_pkg::CTR_W;
    localparam int TABLE_N      = 256;
    localparam int COUNT_W      = 32;
    localparam int OUT_W        = bdp_pkg::OUT_COUNT_W;
    localparam int N_DIRECTED   = 23;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOT_N        = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    // One result as the block reports it.
    typedef struct packed {
        logic             was_taken;
        logic             first_sighting;
        logic             one_bit_guess;
        logic             two_bit_guess;
        logic [OUT_W-1:0] branch_count;
        logic [OUT_W-1:0] taken_count;
        logic [OUT_W-1:0] scored_count;
        logic [OUT_W-1:0] one_bit_hits;
        logic [OUT_W-1:0] two_bit_hits;
    } branch_outcome_t;

    // One row of the directed table; a typed row carries its expected outcome.
    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] mag;
        logic            pos;
        logic [PC_W-1:0] nxt;
        logic            typed;
        branch_outcome_t outcome;
    } branch_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bdp_in_if  branch_bus ();
    bdp_out_if result_bus ();

    branch_direction_predictor #(
        .TABLE_ENTRIES (TABLE_N),
        .COUNT_WIDTH   (COUNT_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch_bus),
        .result (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the predictor table and running counts.
    bit                 tbl_valid [TABLE_N];
    logic [PC_W-1:0]    tbl_tag   [TABLE_N];
    logic               tbl_last  [TABLE_N];
    logic [CTR_W-1:0]   tbl_ctr   [TABLE_N];
    logic [COUNT_W-1:0] cnt_total   = '0;
    logic [COUNT_W-1:0] cnt_taken   = '0;
    logic [COUNT_W-1:0] cnt_scored  = '0;
    logic [COUNT_W-1:0] cnt_one_hit = '0;
    logic [COUNT_W-1:0] cnt_two_hit = '0;

    branch_outcome_t pending_results [$];

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  first_sightings = 0;
    int  tag_conflicts   = 0;
    bit  steady_phase    = 1'b0;
    bit  hold_request    = 1'b0;

    // Random branch pool: the last eight share an index with earlier ones.
    logic [PC_W-1:0] hot_pc   [HOT_N];
    logic [PC_W-1:0] hot_mag  [HOT_N];
    logic            hot_pos  [HOT_N];
    int              hot_bias [HOT_N];

    // Directed table: corner addresses and displacements, wrap-around, tag conflicts,
    // and a counter walk up to saturation, down to zero and back.
    branch_row_t directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0001, 1'b1,
          '{1'b1, 1'b0, 1'b1, 1'b0, 32'd2, 32'd2, 32'd1, 32'd1, 32'd0}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 32'd3, 32'd3, 32'd1, 32'd1, 32'd0}},
        '{32'h0000_0100, 32'h0000_0004, 1'b1, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 32'd4, 32'd3, 32'd1, 32'd1, 32'd0}},
        '{32'h0000_0000, 32'h0000_0008, 1'b0, 32'hFFFF_FFF8, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 32'd5, 32'd4, 32'd1, 32'd1, 32'd0}},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 32'd6, 32'd4, 32'd2, 32'd1, 32'd1}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h1234_5678, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 32'd7, 32'd4, 32'd3, 32'd2, 32'd2}},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1238, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1238, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1238, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1238, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0},
        '{32'h7FFF_FFF0, 32'h8000_0000, 1'b0, 32'hFFFF_FFF0, 1'b0, '0},
        '{32'h7FFF_FFF0, 32'h8000_0000, 1'b1, 32'hFFFF_FFF0, 1'b0, '0},
        '{32'hAAAA_AA55, 32'h5555_5555, 1'b1, 32'hFFFF_FFAA, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAB, 1'b0, '0},
        '{32'h0000_0034, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{32'h8000_1234, 32'h0000_0040, 1'b1, 32'h8000_1274, 1'b0, '0}
    };

    function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Classifies one branch, scores and updates the table, and returns the outcome.
    function automatic branch_outcome_t predict_branch(input logic [PC_W-1:0] pc,
                                                       input logic [PC_W-1:0] mag,
                                                       input logic pos,
                                                       input logic [PC_W-1:0] nxt);
        branch_outcome_t  res;
        logic [PC_W-1:0]  target;
        logic [PC_W-1:0]  tag;
        logic [CTR_W-1:0] ctr;
        int unsigned      idx;
        bit               taken;
        bit               hit;

        target = pos ? pc + mag : pc - mag;
        taken  = (nxt == target);
        idx    = pc % TABLE_N;
        tag    = pc / TABLE_N;
        hit    = tbl_valid[idx] && (tbl_tag[idx] == tag);
        res    = '0;

        cnt_total = sat_bump(cnt_total);
        if (taken)
            cnt_taken = sat_bump(cnt_taken);

        if (hit)
        begin
            ctr               = tbl_ctr[idx];
            res.one_bit_guess = tbl_last[idx];
            res.two_bit_guess = ctr[1];
            cnt_scored = sat_bump(cnt_scored);
            if (res.one_bit_guess == taken)
                cnt_one_hit = sat_bump(cnt_one_hit);
            if (res.two_bit_guess == taken)
                cnt_two_hit = sat_bump(cnt_two_hit);
            tbl_last[idx] = taken;
            if (taken && ctr != 2'd3)
                ctr = ctr + 1'b1;
            else if (!taken && ctr != 2'd0)
                ctr = ctr - 1'b1;
            tbl_ctr[idx] = ctr;
        end
        else
        begin
            if (tbl_valid[idx])
                tag_conflicts++;
            first_sightings++;
            tbl_valid[idx] = 1'b1;
            tbl_tag[idx]   = tag;
            tbl_last[idx]  = 1'b1;
            tbl_ctr[idx]   = '0;
        end

        res.was_taken      = taken;
        res.first_sighting = !hit;
        res.branch_count   = OUT_W'(cnt_total);
        res.taken_count    = OUT_W'(cnt_taken);
        res.scored_count   = OUT_W'(cnt_scored);
        res.one_bit_hits   = OUT_W'(cnt_one_hit);
        res.two_bit_hits   = OUT_W'(cnt_two_hit);
        return res;
    endfunction

    // Presents one request and waits for it to be accepted; valid is left high.
    task automatic offer_branch(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] mag,
                                input logic pos, input logic [PC_W-1:0] nxt,
                                input bit typed, input branch_outcome_t typed_outcome);
        branch_outcome_t predicted;

        branch_bus.valid            <= 1'b1;
        branch_bus.branch_pc        <= pc;
        branch_bus.offset_magnitude <= mag;
        branch_bus.offset_positive  <= pos;
        branch_bus.next_pc          <= nxt;
        @(posedge clk);
        while (!branch_bus.ready)
            @(posedge clk);
        predicted = predict_branch(pc, mag, pos, nxt);
        pending_results.insert(pending_results.size(), typed ? typed_outcome : predicted);
        items_sent++;
    endtask

    // Occasional short gap between requests, except in the steady stretch.
    task automatic maybe_idle();
        int gap;

        if (!steady_phase && $urandom_range(99) < 7)
        begin
            gap = $urandom_range(1, 5);
            branch_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("Result %0d: %s expected %0h, got %0h",
                         results_checked, name, want, got);
        end
    endtask

    // Result side: checks each accepted result and drives ready, with one long hold-off.
    initial
    begin : result_sink
        branch_outcome_t got;
        branch_outcome_t want;
        int              hold_left;
        bit              hold_done;

        hold_left = 0;
        hold_done = 1'b0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                got.was_taken      = result_bus.was_taken;
                got.first_sighting = result_bus.first_sighting;
                got.one_bit_guess  = result_bus.one_bit_guess;
                got.two_bit_guess  = result_bus.two_bit_guess;
                got.branch_count   = result_bus.branch_count;
                got.taken_count    = result_bus.taken_count;
                got.scored_count   = result_bus.scored_count;
                got.one_bit_hits   = result_bus.one_bit_hits;
                got.two_bit_hits   = result_bus.two_bit_hits;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result arrived with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("was_taken", OUT_W'(want.was_taken), OUT_W'(got.was_taken));
                    check_field("first_sighting", OUT_W'(want.first_sighting),
                                OUT_W'(got.first_sighting));
                    check_field("one_bit_guess", OUT_W'(want.one_bit_guess),
                                OUT_W'(got.one_bit_guess));
                    check_field("two_bit_guess", OUT_W'(want.two_bit_guess),
                                OUT_W'(got.two_bit_guess));
                    check_field("branch_count", want.branch_count, got.branch_count);
                    check_field("taken_count", want.taken_count, got.taken_count);
                    check_field("scored_count", want.scored_count, got.scored_count);
                    check_field("one_bit_hits", want.one_bit_hits, got.one_bit_hits);
                    check_field("two_bit_hits", want.two_bit_hits, got.two_bit_hits);
                end
                results_checked++;
            end

            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= steady_phase || ($urandom_range(99) >= 7);
        end
    end

    // Request side: reset, directed table, random branches, drain and verdict.
    initial
    begin : branch_source
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] mag;
        logic [PC_W-1:0] nxt;
        logic [PC_W-1:0] target;
        logic            pos;
        int              pick;

        branch_bus.valid            <= 1'b0;
        branch_bus.branch_pc        <= '0;
        branch_bus.offset_magnitude <= '0;
        branch_bus.offset_positive  <= 1'b0;
        branch_bus.next_pc          <= '0;

        // Build the pool of recurring branches.
        for (int i = 0; i < HOT_N; i++)
        begin
            if (i < HOT_N - 8)
                hot_pc[i] = $urandom();
            else
                hot_pc[i] = hot_pc[i - (HOT_N - 8)]
                            ^ (32'($urandom_range(1, 32'h00FF_FFFF)) << 8);
            hot_mag[i] = $urandom_range(1) ? 32'($urandom_range(0, 8192)) : 32'($urandom());
            hot_pos[i] = 1'($urandom_range(1));
            case ($urandom_range(2))
                0:       hot_bias[i] = 3;
                1:       hot_bias[i] = 50;
                default: hot_bias[i] = 97;
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            offer_branch(directed_rows[r].pc, directed_rows[r].mag, directed_rows[r].pos,
                         directed_rows[r].nxt, directed_rows[r].typed,
                         directed_rows[r].outcome);
            maybe_idle();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_phase = (n >= 700 && n < 950);
            if (n == 400)
                hold_request = 1'b1;

            // Let the block drain completely once before carrying on.
            if (n == 1100)
            begin
                branch_bus.valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            // Now and then a branch changes its behaviour.
            if (n % 150 == 0)
            begin
                pick = $urandom_range(0, HOT_N - 1);
                hot_bias[pick] = $urandom_range(1) ? 100 - hot_bias[pick] : 50;
            end

            if ($urandom_range(99) < 85)
            begin
                pick   = $urandom_range(0, HOT_N - 1);
                pc     = hot_pc[pick];
                mag    = hot_mag[pick];
                pos    = hot_pos[pick];
                target = pos ? pc + mag : pc - mag;
                nxt    = ($urandom_range(99) < hot_bias[pick]) ? target : pc + 32'd4;
            end
            else
            begin
                pc     = $urandom();
                mag    = $urandom();
                pos    = 1'($urandom_range(1));
                target = pos ? pc + mag : pc - mag;
                nxt    = $urandom_range(1) ? target : 32'($urandom());
            end
            offer_branch(pc, mag, pos, nxt, 1'b0, '0);
            maybe_idle();
        end
        steady_phase = 1'b0;
        branch_bus.valid <= 1'b0;

        // Wait for the last results, then keep watching for anything stray before the verdict.
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Ran %0d branches (%0d from the directed table), %0d results checked.",
                 items_sent, N_DIRECTED, results_checked);
        $display("Saw %0d first sightings (%0d tag conflicts), %0d scored, %0d mismatches.",
                 first_sightings, tag_conflicts, cnt_scored, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("branch_direction_predictor: match");
        else
            $display("branch_direction_predictor: mismatch");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : run_limit
        #2_000_000;
        $display("Run stopped at the time limit with %0d results outstanding.",
                 pending_results.size());
        $display("branch_direction_predictor: mismatch");
        $finish;
    end

endmodule
